/* rtl/core/assert_macros.svh */
// Assertion macros shared by the tokenizer RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SEXPT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SEXPT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/sexpt_pkg.sv */
// Shared types and constants of the S-expression tokenizer.
// No dependencies; imported by sexpt_lex and s_expression_tokenizer.
package sexpt_pkg;

   // Token kinds, as carried on the last beat of every token.
   localparam logic [2:0] KIND_EOT    = 3'd0;
   localparam logic [2:0] KIND_OPEN   = 3'd1;
   localparam logic [2:0] KIND_CLOSE  = 3'd2;
   localparam logic [2:0] KIND_QUOTE  = 3'd3;
   localparam logic [2:0] KIND_STRING = 3'd4;
   localparam logic [2:0] KIND_NUMBER = 3'd5;
   localparam logic [2:0] KIND_BOOL   = 3'd6;
   localparam logic [2:0] KIND_SYMBOL = 3'd7;

   // Character codes the lexer recognises.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_OPEN   = 8'h28;
   localparam logic [7:0] CH_CLOSE  = 8'h29;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_F      = 8'h66;

   // One result beat.
   typedef struct packed {
      logic [7:0] sym_char;
      logic       char_present;
      logic       token_end;
      logic [2:0] token_kind;
      logic       unterminated_string;
   } result_type;

   // What the lexer produces for one accepted byte: zero, one or two beats.
   typedef struct packed {
      logic [1:0] n_beats;
      result_type first;
      result_type second;
   } lex_out_type;

endpackage

/* rtl/core/sexpt_lex.sv */
// Lexer core: look-ahead register, lexer mode and the per-byte classification.
// Depends on sexpt_pkg.
module sexpt_lex (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            text_byte,
   output sexpt_pkg::lex_out_type lex_out
);
   import sexpt_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_STRING = 3'd1,
      MODE_CLOSEQ = 3'd2,
      MODE_NUMBER = 3'd3,
      MODE_SYMBOL = 3'd4,
      MODE_BOOL2  = 3'd5
   } mode_type;

   typedef struct packed {
      logic       valid;
      result_type res;
      mode_type   mode;
   } handle_type;

   mode_type   mode_ff, mode_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       held_valid_ff, held_valid_in;

   function automatic logic is_ws(logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic num_continues(logic [7:0] c);
      return (c inside {[8'h30:8'h39]}) || (c == CH_DOT);
   endfunction

   function automatic logic sym_continues(logic [7:0] c);
      return (c != CH_NUL) && !is_ws(c) && !(c inside {CH_OPEN, CH_CLOSE, CH_QUOTE});
   endfunction

   // Handles one non-zero character c with look-ahead nc.
   function automatic handle_type handle_char(logic [7:0] c, logic [7:0] nc, mode_type mode);
      handle_type h;
      h = '0;
      h.mode = mode;
      h.res.sym_char = c;
      h.res.char_present = 1'b1;
      case (mode)
         MODE_STRING: begin
            h.valid = 1'b1;
            if (nc == CH_DQUOTE) begin
               h.res.token_end = 1'b1;
               h.res.token_kind = KIND_STRING;
               h.mode = MODE_CLOSEQ;
            end
         end
         MODE_CLOSEQ: begin
            h.mode = MODE_IDLE;
         end
         MODE_NUMBER, MODE_SYMBOL: begin
            h.valid = 1'b1;
            if (!((mode == MODE_NUMBER) ? num_continues(nc) : sym_continues(nc))) begin
               h.res.token_end = 1'b1;
               h.res.token_kind = (mode == MODE_NUMBER) ? KIND_NUMBER : KIND_SYMBOL;
               h.mode = MODE_IDLE;
            end
         end
         MODE_BOOL2: begin
            h.valid = 1'b1;
            h.res.token_end = 1'b1;
            h.res.token_kind = KIND_BOOL;
            h.mode = MODE_IDLE;
         end
         default: begin
            // Between tokens; unused codes behave the same way.
            h.mode = MODE_IDLE;
            if (is_ws(c)) begin
               h.valid = 1'b0;
            end else if (c inside {CH_OPEN, CH_CLOSE, CH_QUOTE}) begin
               h.valid = 1'b1;
               h.res.token_end = 1'b1;
               h.res.token_kind = (c == CH_OPEN) ? KIND_OPEN :
                                  (c == CH_CLOSE) ? KIND_CLOSE : KIND_QUOTE;
            end else if (c == CH_DQUOTE) begin
               if (nc == CH_DQUOTE) begin
                  h.valid = 1'b1;
                  h.res.sym_char = CH_NUL;
                  h.res.char_present = 1'b0;
                  h.res.token_end = 1'b1;
                  h.res.token_kind = KIND_STRING;
                  h.mode = MODE_CLOSEQ;
               end else begin
                  h.mode = MODE_STRING;
               end
            end else if ((c == CH_MINUS) || (c inside {[8'h30:8'h39]})) begin
               h.valid = 1'b1;
               if (num_continues(nc)) begin
                  h.mode = MODE_NUMBER;
               end else begin
                  h.res.token_end = 1'b1;
                  h.res.token_kind = (c == CH_MINUS) ? KIND_SYMBOL : KIND_NUMBER;
               end
            end else if ((c == CH_HASH) && ((nc == CH_T) || (nc == CH_F))) begin
               h.valid = 1'b1;
               h.mode = MODE_BOOL2;
            end else begin
               h.valid = 1'b1;
               if (sym_continues(nc)) begin
                  h.mode = MODE_SYMBOL;
               end else begin
                  h.res.token_end = 1'b1;
                  h.res.token_kind = KIND_SYMBOL;
               end
            end
         end
      endcase
      return h;
   endfunction

   handle_type held_h;
   mode_type   mode_after;
   logic       held_beat;
   result_type eot_beat;

   always_comb begin
      held_h     = handle_char(held_char_ff, text_byte, mode_ff);
      held_beat  = held_valid_ff && held_h.valid;
      mode_after = held_valid_ff ? held_h.mode : mode_ff;

      eot_beat = '0;
      eot_beat.token_end = 1'b1;
      eot_beat.token_kind = KIND_EOT;
      eot_beat.unterminated_string = (mode_after == MODE_STRING);

      lex_out = '0;
      if (text_byte != CH_NUL) begin
         lex_out.n_beats = {1'b0, held_beat};
         lex_out.first   = held_h.res;
         mode_in         = mode_after;
         held_char_in    = text_byte;
         held_valid_in   = 1'b1;
      end else begin
         if (held_beat) begin
            lex_out.n_beats = 2'd2;
            lex_out.first   = held_h.res;
            lex_out.second  = eot_beat;
         end else begin
            lex_out.n_beats = 2'd1;
            lex_out.first   = eot_beat;
         end
         mode_in       = MODE_IDLE;
         held_char_in  = CH_NUL;
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         held_char_ff  <= CH_NUL;
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

/* rtl/core/s_expression_tokenizer.sv */
// Top level of the S-expression tokenizer: lexer core plus a four-beat result queue.
// Depends on sexpt_pkg, sexpt_lex and assert_macros.svh.
`include "assert_macros.svh"

// The tokenizer takes one text byte per beat on the req_ channel, a zero byte
// marking the end of the text, and streams the characters of each token out on
// the rsp_ channel, one beat per character. The last beat of a token has
// token_end set and carries the token's kind; an empty string gives a single
// beat with char_present low, and the end of text gives its own beat of kind
// zero, with unterminated_string set if the text ended inside a quoted string.
// Each byte is held back by one beat so that the following byte can serve as
// look-ahead, so a token's beats appear one input beat late. A byte is accepted
// in every cycle as long as the result queue has two free entries; results are
// written into a four-entry queue in the same cycle as the byte is accepted and
// leave it from the head, one per cycle unless rsp_stall holds them. Most bytes
// give zero or one result beat; only the end-of-text byte can give two, which
// the queue absorbs, so with a consumer that never stalls the input never stalls.

module s_expression_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_sym_char,
   output logic       rsp_char_present,
   output logic       rsp_token_end,
   output logic [2:0] rsp_token_kind,
   output logic       rsp_unterminated_string
);
   import sexpt_pkg::*;

   localparam int QDEPTH = 4;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);

   lex_out_type lex_out;
   logic        req_accept;
   logic        rsp_pop;

   result_type       queue_ff [QDEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] push_cnt;
   logic [CNT_W-1:0] pop_cnt;
   result_type       head;

   sexpt_lex u_lex (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .text_byte (req_text_byte),
      .lex_out   (lex_out)
   );

   // A byte may bring two beats, so it is only taken with two entries free.
   assign req_stall  = (count_ff > CNT_W'(QDEPTH - 2));
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid = (count_ff != '0);
   assign rsp_pop   = rsp_valid && !rsp_stall;

   assign push_cnt    = req_accept ? CNT_W'(lex_out.n_beats) : '0;
   assign pop_cnt     = CNT_W'(rsp_pop);
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      count_in  = count_ff + push_cnt - pop_cnt;
      rd_ptr_in = rd_ptr_ff + PTR_W'(rsp_pop);
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
      if (push_cnt != '0) begin
         queue_ff[wr_ptr_ff] <= lex_out.first;
      end
      if (push_cnt == CNT_W'(2)) begin
         queue_ff[wr_ptr_next] <= lex_out.second;
      end
   end

   assign head                    = queue_ff[rd_ptr_ff];
   assign rsp_sym_char            = head.sym_char;
   assign rsp_char_present        = head.char_present;
   assign rsp_token_end           = head.token_end;
   assign rsp_token_kind          = head.token_kind;
   assign rsp_unterminated_string = head.unterminated_string;

   // The queue never overfills, and its fill level follows pushes and pops.
   `SEXPT_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(QDEPTH), "result queue overfilled")
   `SEXPT_ASSERT(a_count_track, clock, reset, !$past(reset) |-> (count_ff == $past(count_ff) + $past(push_cnt) - $past(pop_cnt)), "queue fill level lost track")
   // The open-string flag only ever rides on an end-of-text beat.
   `SEXPT_ASSERT(a_unterm_eot, clock, reset, (rsp_valid && rsp_unterminated_string) |-> (rsp_token_end && (rsp_token_kind == KIND_EOT) && !rsp_char_present), "open-string flag on a beat that is not end of text")
   // A beat inside a token carries no kind.
   `SEXPT_ASSERT(a_kind_at_end, clock, reset, (rsp_valid && !rsp_token_end) |-> ((rsp_token_kind == KIND_EOT) && rsp_char_present), "kind or missing character inside a token")

endmodule
